### hw/rtl/windowed_stream_statistics_core_macros.svh
// assertion macros used by the controller rtl
`ifndef WINDOWED_STREAM_STATISTICS_CORE_MACROS_SVH
`define WINDOWED_STREAM_STATISTICS_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked at every clock edge outside reset
`define WSS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("wss check failed");
// checked at every clock edge, reset included
`define WSS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("wss check failed");
`else
`define WSS_ASSERT(lbl, prop)
`define WSS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/wss_pkg.sv
package wss_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_WINDOW_DEF  = 65536;

   localparam int MODE_BITS = 2;
   localparam int WL_BITS   = 17;

   localparam logic [MODE_BITS-1:0] MODE_LAST = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DEV  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MEAN = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd3;

   localparam logic [WL_BITS-1:0] WL_RESET = 17'd1024;

   localparam logic REG_MODE   = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   typedef enum logic [7:0] {
      ST_ACCUM     = 8'b0000_0001,
      ST_MEAN_DIV  = 8'b0000_0010,
      ST_DEV_MUL   = 8'b0000_0100,
      ST_DEV_SUB   = 8'b0000_1000,
      ST_DEV_DIV   = 8'b0001_0000,
      ST_SQRT_LOAD = 8'b0010_0000,
      ST_SQRT      = 8'b0100_0000,
      ST_LOAD      = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic mul;
      logic dev_load;
      logic sqrt_load;
      logic sqrt_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic                 will_close;
      logic                 out_free;
      logic                 div_last;
      logic                 sqrt_last;
      logic [MODE_BITS-1:0] held_mode;
   } status_type;

endpackage

### hw/rtl/wss_datapath.sv
module wss_datapath #(
   parameter int SAMPLE_BITS = wss_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wss_pkg::MAX_WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wss_pkg::cmd_type              cmd,
   output wss_pkg::status_type           status,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic [wss_pkg::MODE_BITS-1:0] cfg_mode,
   input  logic [wss_pkg::WL_BITS-1:0]   cfg_window,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic [SAMPLE_BITS-1:0]        out_value,
   output logic [wss_pkg::MODE_BITS-1:0] out_mode
);
   import wss_pkg::*;

   localparam int CB   = $clog2(MAX_WINDOW + 1);
   localparam int SW   = SAMPLE_BITS + CB;
   localparam int QW   = 2 * SAMPLE_BITS + CB;
   localparam int DW   = QW + 1;
   localparam int SQW  = DW + (DW % 2);
   localparam int RW   = SQW / 2;
   localparam int ITW  = $clog2(DW);
   localparam int CMPW = ((CB > WL_BITS) ? CB : WL_BITS) + 1;

   // window accumulators
   logic [CB-1:0]        count_ff, count_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [QW-1:0]        sq_ff, sq_in;
   // snapshot of a closed window
   logic                 neg_ff, neg_in;
   logic signed [SW-1:0] hsum_ff, hsum_in;
   logic [QW-1:0]        hsq_ff, hsq_in;
   logic [CB-1:0]        n_ff, n_in;
   logic [MODE_BITS-1:0] mode_ff, mode_in;
   // shared divider, multiplier, root unit
   logic [DW-1:0]        dd_ff, dd_in;
   logic [CB-1:0]        rem_ff, rem_in;
   logic [ITW-1:0]       iter_ff, iter_in;
   logic signed [DW-1:0] prod_ff, prod_in;
   logic [SQW-1:0]       sv_ff, sv_in;
   logic [RW-1:0]        root_ff, root_in;
   logic [RW:0]          srem_ff, srem_in;
   // result register
   logic                   ov_ff, ov_in;
   logic [SAMPLE_BITS-1:0] oval_ff, oval_in;
   logic [MODE_BITS-1:0]   omode_ff, omode_in;

   logic signed [SAMPLE_BITS-1:0]   x_s;
   logic [2*SAMPLE_BITS-1:0]        x_sq;
   logic [CB-1:0]                   count_nx;
   logic signed [SW-1:0]            sum_nx;
   logic [QW-1:0]                   sq_nx;
   logic [SW-1:0]                   sum_abs;
   logic [CMPW-1:0]                 eff_win;
   logic                            close;
   logic [CB:0]                     dshift;
   logic                            dge;
   logic signed [SAMPLE_BITS+1:0]   m_s;
   logic signed [CB:0]              r_s;
   logic signed [SW:0]              t_s;
   logic signed [SW+SAMPLE_BITS+2:0] p_full;
   logic [RW+2:0]                   scand;
   logic [RW+1:0]                   strial;
   logic                            sge;
   logic                            out_free;
   logic [DW-1:0]                   pick;
   logic [DW-1:0]                   smax;

   always_comb begin
      x_s      = signed'(sample);
      // square at full width, the product of the most negative sample needs it
      x_sq     = unsigned'((2*SAMPLE_BITS)'(x_s) * (2*SAMPLE_BITS)'(x_s));
      count_nx = count_ff + CB'(1);
      sum_nx   = sum_ff + SW'(x_s);
      sq_nx    = sq_ff + QW'(x_sq);
      sum_abs  = sum_nx[SW-1] ? unsigned'(-sum_nx) : unsigned'(sum_nx);
      if (cfg_window == '0) begin
         eff_win = CMPW'(1);
      end else if (CMPW'(cfg_window) > CMPW'(MAX_WINDOW)) begin
         eff_win = CMPW'(MAX_WINDOW);
      end else begin
         eff_win = CMPW'(cfg_window);
      end
      close    = CMPW'(count_nx) >= eff_win;
      out_free = !ov_ff || out_ready;

      dshift = {rem_ff, dd_ff[DW-1]};
      dge    = dshift >= {1'b0, n_ff};

      m_s    = neg_ff ? -signed'({1'b0, dd_ff[SAMPLE_BITS:0]})
                      : signed'({1'b0, dd_ff[SAMPLE_BITS:0]});
      r_s    = neg_ff ? -signed'({1'b0, rem_ff}) : signed'({1'b0, rem_ff});
      t_s    = (SW+1)'(hsum_ff) + (SW+1)'(r_s);
      p_full = m_s * t_s;

      scand  = {srem_ff, sv_ff[SQW-1:SQW-2]};
      strial = {root_ff, 2'b01};
      sge    = scand >= (RW+3)'(strial);

      smax   = DW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      pick   = (mode_ff == MODE_MEAN) ? dd_ff : DW'(root_ff);
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      neg_in   = neg_ff;
      hsum_in  = hsum_ff;
      hsq_in   = hsq_ff;
      n_in     = n_ff;
      mode_in  = mode_ff;
      dd_in    = dd_ff;
      rem_in   = rem_ff;
      iter_in  = iter_ff;
      prod_in  = prod_ff;
      sv_in    = sv_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      ov_in    = ov_ff && !out_ready;
      oval_in  = oval_ff;
      omode_in = omode_ff;

      if (cmd.accept) begin
         if (close) begin
            count_in = '0;
            sum_in   = '0;
            sq_in    = '0;
            neg_in   = sum_nx[SW-1];
            hsum_in  = sum_nx;
            hsq_in   = sq_nx;
            n_in     = count_nx;
            mode_in  = cfg_mode;
            dd_in    = DW'(sum_abs);
            rem_in   = '0;
            iter_in  = '0;
            if (cfg_mode == MODE_LAST) begin
               ov_in    = 1'b1;
               oval_in  = sample;
               omode_in = cfg_mode;
            end
         end else begin
            count_in = count_nx;
            sum_in   = sum_nx;
            sq_in    = sq_nx;
         end
      end

      if (cmd.div_step) begin
         rem_in  = dge ? CB'(dshift - {1'b0, n_ff}) : CB'(dshift);
         dd_in   = {dd_ff[DW-2:0], dge};
         iter_in = iter_ff + ITW'(1);
      end

      if (cmd.mul) begin
         prod_in = p_full[DW-1:0];
      end

      if (cmd.dev_load) begin
         dd_in   = {1'b0, hsq_ff} - unsigned'(prod_ff);
         rem_in  = '0;
         iter_in = '0;
      end

      if (cmd.sqrt_load) begin
         sv_in   = SQW'(dd_ff);
         root_in = '0;
         srem_in = '0;
         iter_in = '0;
      end

      if (cmd.sqrt_step) begin
         srem_in = sge ? (RW+1)'(scand - (RW+3)'(strial)) : (RW+1)'(scand);
         root_in = {root_ff[RW-2:0], sge};
         sv_in   = {sv_ff[SQW-3:0], 2'b00};
         iter_in = iter_ff + ITW'(1);
      end

      if (cmd.load_out) begin
         ov_in    = 1'b1;
         oval_in  = (pick > smax) ? smax[SAMPLE_BITS-1:0] : pick[SAMPLE_BITS-1:0];
         omode_in = mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         ov_ff    <= 1'b0;
         iter_ff  <= '0;
         mode_ff  <= MODE_LAST;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         ov_ff    <= ov_in;
         iter_ff  <= iter_in;
         mode_ff  <= mode_in;
      end
      neg_ff   <= neg_in;
      hsum_ff  <= hsum_in;
      hsq_ff   <= hsq_in;
      n_ff     <= n_in;
      dd_ff    <= dd_in;
      rem_ff   <= rem_in;
      prod_ff  <= prod_in;
      sv_ff    <= sv_in;
      root_ff  <= root_in;
      srem_ff  <= srem_in;
      oval_ff  <= oval_in;
      omode_ff <= omode_in;
   end

   always_comb begin
      status.will_close = close;
      status.out_free   = out_free;
      status.div_last   = iter_ff == ITW'(DW - 1);
      status.sqrt_last  = iter_ff == ITW'(RW - 1);
      status.held_mode  = mode_ff;
   end

   assign out_valid = ov_ff;
   assign out_value = oval_ff;
   assign out_mode  = omode_ff;

endmodule

### hw/rtl/wss_controller.sv
`include "windowed_stream_statistics_core_macros.svh"

module wss_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [wss_pkg::MODE_BITS-1:0] cfg_mode,
   input  wss_pkg::status_type           status,
   output wss_pkg::cmd_type              cmd
);
   import wss_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            in_ready   = !status.will_close || status.out_free;
            cmd.accept = in_valid && in_ready;
            if (cmd.accept && status.will_close &&
                (cfg_mode == MODE_DEV || cfg_mode == MODE_MEAN)) begin
               state_in = ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = (status.held_mode == MODE_MEAN) ? ST_LOAD : ST_DEV_MUL;
            end
         end
         ST_DEV_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DEV_SUB;
         end
         ST_DEV_SUB: begin
            cmd.dev_load = 1'b1;
            state_in     = ST_DEV_DIV;
         end
         ST_DEV_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SQRT_LOAD;
            end
         end
         ST_SQRT_LOAD: begin
            cmd.sqrt_load = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_out = status.out_free;
            if (status.out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   `WSS_ASSERT(a_load_returns, (state_ff == ST_LOAD && status.out_free) |=> state_ff == ST_ACCUM)
   `WSS_ASSERT(a_root_done, (state_ff == ST_SQRT && status.sqrt_last) |=> state_ff == ST_LOAD)
   `WSS_ASSERT(a_mean_done, (state_ff == ST_MEAN_DIV && status.div_last && status.held_mode == MODE_MEAN) |=> state_ff == ST_LOAD)
   `WSS_ASSERT_ALWAYS(a_load_free, cmd.load_out |-> status.out_free)

endmodule

### hw/rtl/windowed_stream_statistics_core.sv
// channel    | group   | payload
// -----------+---------+-------------------------------------------
// samples in | req_    | tdata: sample
// results    | rsp_    | tdata: result_value, tuser: result_mode
// registers  | csr_    | 0x0 mode_select, 0x4 window_length
//
// one sample per cycle inside a window (but see the stall below), the accumulators update on the fly
// closing a window in mean mode runs the one-bit-per-cycle shared divider on a DW-bit dividend
// (DW = 2*SAMPLE_BITS+clog2(MAX_WINDOW+1)+1, 50 at the defaults), then loads the result
// deviation mode runs the divider, the multiplier, a subtraction, the divider again,
// then the two-bit-per-cycle square root
// last-sample mode and the unused mode go straight back to accumulating
// synchronous active-high reset clears control state and loads register defaults
// a result waits in the output register; samples keep flowing unless a window
// closes while that register is still full or while a mean or deviation is computed
module windowed_stream_statistics_core #(
   parameter int SAMPLE_BITS = wss_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wss_pkg::MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample transactions
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,  // sample
   // result transactions
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,  // result_value
   output logic [wss_pkg::MODE_BITS-1:0]        rsp_tuser,  // result_mode
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [2:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import wss_pkg::*;

   localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [WL_BITS-1:0]     window_ff, window_in;
   logic                   csr_wr;
   cmd_type                cmd;
   status_type             status;
   logic [SAMPLE_BITS-1:0] out_value;

   // register writes complete in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in   = mode_ff;
      window_in = window_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MODE:   mode_in   = csr_pwdata[MODE_BITS-1:0];
            REG_WINDOW: window_in = csr_pwdata[WL_BITS-1:0];
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LAST;
         window_ff <= WL_RESET;
      end else begin
         mode_ff   <= mode_in;
         window_ff <= window_in;
      end
   end

   // read back
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW) ? 32'(window_ff) : 32'(mode_ff);

   wss_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .cfg_mode (mode_ff),
      .status   (status),
      .cmd      (cmd)
   );

   wss_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .cfg_mode   (mode_ff),
      .cfg_window (window_ff),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_value  (out_value),
      .out_mode   (rsp_tuser)
   );

   // zero padding up to whole bytes
   assign rsp_tdata = TDW'(out_value);

endmodule
